// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pli_pkg.sv =====
package pli_pkg;

    localparam int MAX_NODES = 64;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int STEP_W    = $clog2(DATA_W);

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_QUERY = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_RANGE = 3'd1,
        ST_DUP   = 3'd2,
        ST_EMPTY = 3'd3,
        ST_FULL  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_L_SCAN_RD,
        S_L_SCAN_CMP,
        S_L_SH_RD,
        S_L_SH_WR,
        S_L_INS,
        S_Q_LAST_RD,
        S_Q_LAST_CMP,
        S_Q_SCAN_RD,
        S_Q_SCAN_CMP,
        S_Q_MUL,
        S_Q_DIV,
        S_Q_FIN,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_TOP,
        IDX_ZERO,
        IDX_DEC,
        IDX_INC
    } idx_op_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_NODE_Y,
        RES_INTERP
    } res_src_t;

    typedef struct packed {
        logic     capture;
        idx_op_t  idx_op;
        logic     pos_next;
        logic     shift_wr;
        logic     insert;
        logic     clear;
        logic     set_bad;
        logic     save_prev;
        logic     bracket;
        logic     mul_step;
        logic     div_step;
        logic     res_we;
        status_t  res_status;
        res_src_t res_src;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  count_zero;
        logic  count_full;
        logic  bad;
        logic  node_eq;
        logic  node_gt;
        logic  idx_zero;
        logic  idx_top;
        logic  idx_at_pos;
        logic  step_last;
        logic  out_busy;
    } sts_t;

endpackage

// ===== sv/pli_ram.sv =====
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/pli_ctrl.sv =====
module pli_ctrl
    import pli_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.res_src = RES_ZERO;
                unique case (sts.kind)
                    KIND_CLEAR:
                    begin
                        cmd.clear      = 1'b1;
                        cmd.res_we     = 1'b1;
                        cmd.res_status = ST_OK;
                        state_next     = S_DONE;
                    end
                    KIND_LOAD:
                    begin
                        if (sts.count_full)
                        begin
                            cmd.res_we     = 1'b1;
                            cmd.res_status = ST_FULL;
                            state_next     = S_DONE;
                        end
                        else if (sts.count_zero)
                        begin
                            state_next = S_L_INS;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_TOP;
                            state_next = S_L_SCAN_RD;
                        end
                    end
                    KIND_QUERY:
                    begin
                        if (sts.bad)
                        begin
                            cmd.res_we     = 1'b1;
                            cmd.res_status = ST_DUP;
                            state_next     = S_DONE;
                        end
                        else if (sts.count_zero)
                        begin
                            cmd.res_we     = 1'b1;
                            cmd.res_status = ST_EMPTY;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_TOP;
                            state_next = S_Q_LAST_RD;
                        end
                    end
                    default:
                    begin
                        cmd.res_we     = 1'b1;
                        cmd.res_status = ST_OK;
                        state_next     = S_DONE;
                    end
                endcase
            end
            S_L_SCAN_RD:
            begin
                state_next = S_L_SCAN_CMP;
            end
            S_L_SCAN_CMP:
            begin
                priority if (sts.node_eq)
                begin
                    cmd.set_bad    = 1'b1;
                    cmd.res_we     = 1'b1;
                    cmd.res_status = ST_DUP;
                    state_next     = S_DONE;
                end
                else if (sts.node_gt)
                begin
                    if (sts.idx_zero)
                    begin
                        cmd.idx_op = IDX_TOP;
                        state_next = S_L_SH_RD;
                    end
                    else
                    begin
                        cmd.idx_op = IDX_DEC;
                        state_next = S_L_SCAN_RD;
                    end
                end
                else
                begin
                    cmd.pos_next = 1'b1;
                    if (sts.idx_top)
                    begin
                        state_next = S_L_INS;
                    end
                    else
                    begin
                        cmd.idx_op = IDX_TOP;
                        state_next = S_L_SH_RD;
                    end
                end
            end
            S_L_SH_RD:
            begin
                state_next = S_L_SH_WR;
            end
            S_L_SH_WR:
            begin
                cmd.shift_wr = 1'b1;
                if (sts.idx_at_pos)
                begin
                    state_next = S_L_INS;
                end
                else
                begin
                    cmd.idx_op = IDX_DEC;
                    state_next = S_L_SH_RD;
                end
            end
            S_L_INS:
            begin
                cmd.insert     = 1'b1;
                cmd.res_we     = 1'b1;
                cmd.res_status = ST_OK;
                state_next     = S_DONE;
            end
            S_Q_LAST_RD:
            begin
                state_next = S_Q_LAST_CMP;
            end
            S_Q_LAST_CMP:
            begin
                if (!sts.node_eq && !sts.node_gt)
                begin
                    cmd.res_we     = 1'b1;
                    cmd.res_status = ST_RANGE;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.idx_op = IDX_ZERO;
                    state_next = S_Q_SCAN_RD;
                end
            end
            S_Q_SCAN_RD:
            begin
                state_next = S_Q_SCAN_CMP;
            end
            S_Q_SCAN_CMP:
            begin
                priority if (sts.node_eq)
                begin
                    cmd.res_we     = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_src    = RES_NODE_Y;
                    state_next     = S_DONE;
                end
                else if (sts.node_gt)
                begin
                    if (sts.idx_zero)
                    begin
                        cmd.res_we     = 1'b1;
                        cmd.res_status = ST_RANGE;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        cmd.bracket = 1'b1;
                        state_next  = S_Q_MUL;
                    end
                end
                else
                begin
                    cmd.save_prev = 1'b1;
                    cmd.idx_op    = IDX_INC;
                    state_next    = S_Q_SCAN_RD;
                end
            end
            S_Q_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (sts.step_last)
                begin
                    state_next = S_Q_DIV;
                end
            end
            S_Q_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.step_last)
                begin
                    state_next = S_Q_FIN;
                end
            end
            S_Q_FIN:
            begin
                cmd.res_we     = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_src    = RES_INTERP;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/pli_dp.sv =====
module pli_dp
    import pli_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [1:0]        in_kind,
    input  logic [DATA_W-1:0] in_node_x,
    input  logic [DATA_W-1:0] in_node_y,
    input  logic [DATA_W-1:0] in_query_point,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_value,
    output logic [2:0]        out_status
);

    // Control state.
    logic [CNT_W-1:0] count_reg;
    logic             bad_reg;
    logic             out_valid_reg;

    // Payload.
    kind_t             kind_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] yin_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [DATA_W-1:0] prev_x_reg;
    logic [DATA_W-1:0] prev_y_reg;
    logic [DATA_W-1:0] y0_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] mag_reg;
    logic [DATA_W-1:0] dx_reg;
    logic [DATA_W-1:0] hi_reg;
    logic [DATA_W-1:0] lo_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DATA_W-1:0] res_value_reg;
    status_t           res_status_reg;
    logic [DATA_W-1:0] out_value_reg;
    status_t           out_status_reg;

    logic [DATA_W-1:0] rx;
    logic [DATA_W-1:0] ry;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [DATA_W-1:0] mem_wx;
    logic [DATA_W-1:0] mem_wy;
    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  count_dec;
    logic [DATA_W:0]   dy;
    logic [DATA_W:0]   dy_neg;
    logic [DATA_W:0]   mul_sum;
    logic [DATA_W:0]   div_r2;
    logic [DATA_W:0]   div_diff;
    logic              div_ge;
    logic [DATA_W-1:0] interp;

    assign idx_inc   = idx_reg + CNT_W'(1);
    assign count_dec = count_reg - CNT_W'(1);

    assign mem_we    = cmd.shift_wr | cmd.insert;
    assign mem_waddr = cmd.shift_wr ? idx_inc[IDX_W-1:0] : pos_reg[IDX_W-1:0];
    assign mem_wx    = cmd.shift_wr ? rx : key_reg;
    assign mem_wy    = cmd.shift_wr ? ry : yin_reg;

    pli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_NODES)) u_xmem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wx),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (rx)
    );

    pli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_NODES)) u_ymem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wy),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ry)
    );

    assign dy       = {ry[DATA_W-1], ry} - {prev_y_reg[DATA_W-1], prev_y_reg};
    assign dy_neg   = -dy;
    assign mul_sum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mag_reg} : '0);
    assign div_r2   = {hi_reg, lo_reg[DATA_W-1]};
    assign div_diff = div_r2 - {1'b0, dx_reg};
    assign div_ge   = (div_r2 >= {1'b0, dx_reg});
    assign interp   = neg_reg ? (y0_reg - lo_reg) : (y0_reg + lo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
                bad_reg   <= 1'b0;
            end
            else
            begin
                if (cmd.insert)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                if (cmd.set_bad)
                begin
                    bad_reg <= 1'b1;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind_t'(in_kind);
            key_reg  <= (in_kind == KIND_LOAD) ? in_node_x : in_query_point;
            yin_reg  <= in_node_y;
            pos_reg  <= '0;
        end
        if (cmd.pos_next)
        begin
            pos_reg <= idx_inc;
        end
        unique case (cmd.idx_op)
            IDX_TOP:  idx_reg <= count_dec;
            IDX_ZERO: idx_reg <= '0;
            IDX_DEC:  idx_reg <= idx_reg - CNT_W'(1);
            IDX_INC:  idx_reg <= idx_inc;
            default:  idx_reg <= idx_reg;
        endcase
        if (cmd.save_prev)
        begin
            prev_x_reg <= rx;
            prev_y_reg <= ry;
        end
        if (cmd.bracket)
        begin
            y0_reg   <= prev_y_reg;
            neg_reg  <= dy[DATA_W];
            mag_reg  <= dy[DATA_W] ? dy_neg[DATA_W-1:0] : dy[DATA_W-1:0];
            dx_reg   <= rx - prev_x_reg;
            hi_reg   <= '0;
            lo_reg   <= key_reg - prev_x_reg;
            step_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            hi_reg   <= mul_sum[DATA_W:1];
            lo_reg   <= {mul_sum[0], lo_reg[DATA_W-1:1]};
            step_reg <= step_reg + STEP_W'(1);
        end
        else if (cmd.div_step)
        begin
            hi_reg   <= div_ge ? div_diff[DATA_W-1:0] : div_r2[DATA_W-1:0];
            lo_reg   <= {lo_reg[DATA_W-2:0], div_ge};
            step_reg <= step_reg + STEP_W'(1);
        end
        if (cmd.res_we)
        begin
            res_status_reg <= cmd.res_status;
            unique case (cmd.res_src)
                RES_NODE_Y: res_value_reg <= ry;
                RES_INTERP: res_value_reg <= interp;
                default:    res_value_reg <= '0;
            endcase
        end
        if (cmd.emit)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_comb
    begin
        sts.kind       = kind_reg;
        sts.count_zero = (count_reg == '0);
        sts.count_full = (count_reg == CNT_W'(MAX_NODES));
        sts.bad        = bad_reg;
        sts.node_eq    = (rx == key_reg);
        sts.node_gt    = ($signed(rx) > $signed(key_reg));
        sts.idx_zero   = (idx_reg == '0);
        sts.idx_top    = (idx_reg == count_dec);
        sts.idx_at_pos = (idx_reg == pos_reg);
        sts.step_last  = (step_reg == '1);
        sts.out_busy   = out_valid_reg & ~out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

endmodule

// ===== sv/piecewise_linear_interpolator_unit.sv =====
// Channel   Direction  tdata                                  tuser
// s_axis    in         node_x[31:0] node_y[63:32] qp[95:64]   kind[1:0]
// m_axis    out        value[31:0]                            status[2:0]
//
// One word is taken at a time; s_axis_tready is high only while the block is idle.
// Clear and words rejected at dispatch go straight to the output state. A load runs a
// search pass, then a shifting pass, over the stored nodes through the registered-read
// node memories. A query runs the scan up to the bracketing node, then 32 shift-add
// multiply steps and 32 restoring divide steps.
// Reset clears the node count, the duplicate flag and the output valid; memory contents
// are left as they are. A stalled m_axis holds the finished word while the next input
// word is already accepted and worked on.
module piecewise_linear_interpolator_unit
    import pli_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // node_x, node_y, query_point from bit 0 up
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // value
    output logic [2:0]  m_axis_tuser    // status
);

    // Commands from the controller into the datapath, and status flags back.
    cmd_t cmd;
    sts_t sts;

    // The controller sequences the search, shift, multiply and divide steps.
    pli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the sorted node memories, the arithmetic and the output word.
    pli_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_kind        (s_axis_tuser),
        .in_node_x      (s_axis_tdata[31:0]),
        .in_node_y      (s_axis_tdata[63:32]),
        .in_query_point (s_axis_tdata[95:64]),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_value      (m_axis_tdata),
        .out_status     (m_axis_tuser)
    );

endmodule

// ===== sv/pli_checker.sv =====
`include "assert_macros.svh"

module pli_checker
    import pli_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    logic out_stall;
    logic out_fail;
    logic in_take;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_fail  = m_axis_tvalid && (m_axis_tuser != ST_OK);
    assign in_take   = s_axis_tvalid && s_axis_tready;

    // A stalled result word stays offered.
    `ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid, "output word dropped while stalled")

    // A failed status always carries a zero value.
    `ASSERT_IMP(a_fail_zero, out_fail, m_axis_tdata == '0, "nonzero value with failed status")

    // The block leaves idle on a take, so the input is closed right after a take.
    `ASSERT_NXT(a_one_at_a_time, in_take, !s_axis_tready, "input taken on back-to-back cycles")

    // Only defined status codes reach the output.
    `ASSERT_IMP(a_status_code, m_axis_tvalid, m_axis_tuser <= ST_FULL, "undefined status code")

endmodule

bind piecewise_linear_interpolator_unit pli_checker u_pli_checker (.*);
